### design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is low
`define RRTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RRTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rrts_pkg.sv
`default_nettype none
package rrts_pkg;

    localparam int TICK_W = 32;
    localparam int SP_W   = 32;

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_CREATE  = 3'd1,
        CMD_PREEMPT = 3'd2,
        CMD_YIELD   = 3'd3,
        CMD_SLEEP   = 3'd4,
        CMD_EXIT    = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_UNUSED     = 3'd0,
        ST_READY      = 3'd1,
        ST_RUNNING    = 3'd2,
        ST_SLEEPING   = 3'd3,
        ST_TERMINATED = 3'd4
    } t_slot_st;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SWITCH  = 2'd1,
        STAT_NO_FREE    = 2'd2,
        STAT_NONE_READY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR_RD,
        S_CUR_WR,
        S_SCAN,
        S_FIN,
        S_OUT
    } t_seq_state;

    // one entry of the slot memory
    typedef struct packed {
        t_slot_st          st;
        logic [TICK_W-1:0] wake;
    } t_slot_word;

    function automatic logic is_live(input t_slot_st s);
        return (s != ST_UNUSED) && (s != ST_TERMINATED);
    endfunction

endpackage
`default_nettype wire

### design/rrts_if.sv
`default_nettype none
interface rrts_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] initial_sp;
    logic [31:0] saved_sp;
    logic [31:0] sleep_ticks;
    logic [31:0] now_ticks;

    modport source (
        output valid, command, initial_sp, saved_sp, sleep_ticks, now_ticks,
        input  ready
    );
    modport sink (
        input  valid, command, initial_sp, saved_sp, sleep_ticks, now_ticks,
        output ready
    );
endinterface

interface rrts_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  task_index;
    logic [31:0] next_sp;
    logic        switched;
    logic [3:0]  live_count;

    modport source (
        output valid, status, task_index, next_sp, switched, live_count,
        input  ready
    );
    modport sink (
        input  valid, status, task_index, next_sp, switched, live_count,
        output ready
    );
endinterface
`default_nettype wire

### design/rrts_slot_mem.sv
`default_nettype none
module rrts_slot_mem
    import rrts_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_waddr,
    input  wire t_slot_word                    i_wdata,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_raddr,
    output t_slot_word                         o_rdata
);

    t_slot_word              r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   r_valid;
    t_slot_word              r_rdata;
    logic                    r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // per-entry written flags, cleared at once by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    // an entry never written reads as unused
    always_comb begin
        o_rdata = r_rdata;
        if (!r_rvalid) begin
            o_rdata.st = ST_UNUSED;
        end
    end

endmodule
`default_nettype wire

### design/rrts_sp_mem.sv
`default_nettype none
module rrts_sp_mem
    import rrts_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_waddr,
    input  wire logic [SP_W-1:0]               i_wdata,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_raddr,
    output logic [SP_W-1:0]                    o_rdata
);

    logic [SP_W-1:0] r_mem [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/round_robin_task_scheduler_top.sv
// the time from command transaction to result transaction depends on the slot scan
//   (one slot memory read issued per cycle, checked in the following cycle) and on the output
//   register being free; one command at a time: a new command is taken only in the idle state
// reset: synchronous active low; all slots unused, not started, output empty, no clearing pass
`default_nettype none
module round_robin_task_scheduler_top
    import rrts_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rrts_cmd_if.sink     i_cmd,
    rrts_res_if.source   o_res
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // sequencer state
    t_seq_state         r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [SP_W-1:0]    r_isp, n_isp;
    logic [SP_W-1:0]    r_ssp, n_ssp;
    logic [TICK_W-1:0]  r_ticks, n_ticks;
    logic [TICK_W-1:0]  r_now, n_now;

    // scheduler state outside the memories
    logic               r_started, n_started;
    logic [IW-1:0]      r_cur, n_cur;
    t_slot_st           r_cur_st, n_cur_st;
    logic [TICK_W-1:0]  r_cur_wake, n_cur_wake;
    logic [CW-1:0]      r_live, n_live;

    // scan pipeline: issue stage and check stage
    logic [IW-1:0]      r_issue_idx, n_issue_idx;
    logic [CW-1:0]      r_issue_cnt, n_issue_cnt;
    logic [IW-1:0]      r_chk_idx, n_chk_idx;
    logic               r_chk_vld, n_chk_vld;
    logic               r_chk_last, n_chk_last;
    logic [IW-1:0]      r_found, n_found;

    // pending result
    t_status            r_res_status, n_res_status;
    logic [2:0]         r_res_idx, n_res_idx;
    logic [SP_W-1:0]    r_res_sp, n_res_sp;
    logic               r_res_sw, n_res_sw;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               w_out_load;
    t_status            r_o_status;
    logic [2:0]         r_o_idx;
    logic [SP_W-1:0]    r_o_sp;
    logic               r_o_sw;
    logic [3:0]         r_o_live;

    // memory ports
    logic               w_sm_we;
    logic [IW-1:0]      w_sm_waddr;
    t_slot_word         w_sm_wdata;
    logic [IW-1:0]      w_sm_raddr;
    t_slot_word         w_sm_rdata;
    logic               w_sp_we;
    logic [IW-1:0]      w_sp_waddr;
    logic [SP_W-1:0]    w_sp_wdata;
    logic [IW-1:0]      w_sp_raddr;
    logic [SP_W-1:0]    w_sp_rdata;

    logic               w_accept;
    logic               w_match;
    logic [IW-1:0]      w_cur_next;

    // state and wake time per slot, plus written flags
    rrts_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_sm_we),
        .i_waddr (w_sm_waddr),
        .i_wdata (w_sm_wdata),
        .i_raddr (w_sm_raddr),
        .o_rdata (w_sm_rdata)
    );

    // saved stack pointer per slot
    rrts_sp_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_sp_mem (
        .i_clk   (i_clk),
        .i_we    (w_sp_we),
        .i_waddr (w_sp_waddr),
        .i_wdata (w_sp_wdata),
        .i_raddr (w_sp_raddr),
        .o_rdata (w_sp_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_cur_next = (r_cur == IW'(SLOT_COUNT - 1)) ? '0 : r_cur + 1'b1;

    // does the slot in the check stage end the scan
    always_comb begin
        case (r_cmd)
            CMD_CREATE: w_match = (w_sm_rdata.st == ST_UNUSED);
            CMD_START:  w_match = (w_sm_rdata.st == ST_READY);
            default: begin
                // a sleeper whose wake time has been reached counts as ready
                w_match = (w_sm_rdata.st == ST_READY) ||
                          ((w_sm_rdata.st == ST_SLEEPING) && (r_now >= w_sm_rdata.wake));
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_isp        = r_isp;
        n_ssp        = r_ssp;
        n_ticks      = r_ticks;
        n_now        = r_now;
        n_started    = r_started;
        n_cur        = r_cur;
        n_cur_st     = r_cur_st;
        n_cur_wake   = r_cur_wake;
        n_live       = r_live;
        n_issue_idx  = r_issue_idx;
        n_issue_cnt  = r_issue_cnt;
        n_chk_idx    = r_chk_idx;
        n_chk_vld    = 1'b0;
        n_chk_last   = r_chk_last;
        n_found      = r_found;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_sp     = r_res_sp;
        n_res_sw     = r_res_sw;
        w_out_load   = 1'b0;
        n_out_valid  = r_out_valid && !o_res.ready;

        w_sm_we      = 1'b0;
        w_sm_waddr   = r_cur;
        w_sm_wdata   = '{st: ST_UNUSED, wake: '0};
        w_sm_raddr   = r_cur;
        w_sp_we      = 1'b0;
        w_sp_waddr   = r_cur;
        w_sp_wdata   = r_ssp;
        w_sp_raddr   = r_found;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd        = t_cmd'(i_cmd.command);
                    n_isp        = i_cmd.initial_sp;
                    n_ssp        = i_cmd.saved_sp;
                    n_ticks      = i_cmd.sleep_ticks;
                    n_now        = i_cmd.now_ticks;
                    n_res_status = STAT_NO_SWITCH;
                    n_res_idx    = '0;
                    n_res_sp     = '0;
                    n_res_sw     = 1'b0;
                    // scans for start and create run from slot 0
                    n_issue_idx  = '0;
                    n_issue_cnt  = '0;
                    case (t_cmd'(i_cmd.command))
                        CMD_START: begin
                            n_state = r_started ? S_OUT : S_SCAN;
                        end
                        CMD_CREATE: begin
                            n_state = S_SCAN;
                        end
                        CMD_PREEMPT, CMD_YIELD, CMD_SLEEP, CMD_EXIT: begin
                            n_state = r_started ? S_CUR_RD : S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_CUR_RD: begin
                w_sm_raddr = r_cur;
                n_state    = S_CUR_WR;
            end

            S_CUR_WR: begin
                // read-modify-write of the current slot before the scan
                n_cur_st   = w_sm_rdata.st;
                n_cur_wake = w_sm_rdata.wake;
                case (r_cmd)
                    CMD_PREEMPT: begin
                        w_sp_we    = 1'b1;
                        w_sp_waddr = r_cur;
                        w_sp_wdata = r_ssp;
                    end
                    CMD_SLEEP: begin
                        n_cur_st   = ST_SLEEPING;
                        n_cur_wake = r_now + r_ticks;
                        // a terminated current slot comes back to life as a sleeper
                        if (!is_live(w_sm_rdata.st)) begin
                            n_live = r_live + 1'b1;
                        end
                    end
                    CMD_EXIT: begin
                        n_cur_st = ST_TERMINATED;
                        if (is_live(w_sm_rdata.st)) begin
                            n_live = r_live - 1'b1;
                        end
                    end
                    default: ;
                endcase
                w_sm_we     = 1'b1;
                w_sm_waddr  = r_cur;
                w_sm_wdata  = '{st: n_cur_st, wake: n_cur_wake};
                // round robin from the slot after the current one, current slot last
                n_issue_idx = w_cur_next;
                n_issue_cnt = '0;
                n_state     = S_SCAN;
            end

            S_SCAN: begin
                // issue stage: one slot read per cycle
                if (r_issue_cnt != CW'(SLOT_COUNT)) begin
                    w_sm_raddr  = r_issue_idx;
                    n_issue_idx = (r_issue_idx == IW'(SLOT_COUNT - 1)) ? '0
                                                                       : r_issue_idx + 1'b1;
                    n_issue_cnt = r_issue_cnt + 1'b1;
                    n_chk_vld   = 1'b1;
                    n_chk_idx   = r_issue_idx;
                    n_chk_last  = (r_issue_cnt == CW'(SLOT_COUNT - 1));
                end
                // check stage: first hit ends the scan, the read in flight is dropped
                if (r_chk_vld) begin
                    if (w_match) begin
                        n_chk_vld = 1'b0;
                        n_found   = r_chk_idx;
                        w_sm_we   = 1'b1;
                        w_sm_waddr = r_chk_idx;
                        if (r_cmd == CMD_CREATE) begin
                            w_sm_wdata   = '{st: ST_READY, wake: '0};
                            w_sp_we      = 1'b1;
                            w_sp_waddr   = r_chk_idx;
                            w_sp_wdata   = r_isp;
                            n_live       = r_live + 1'b1;
                            n_res_status = STAT_OK;
                            n_res_idx    = 3'(r_chk_idx);
                            n_state      = S_OUT;
                        end else begin
                            w_sm_wdata = '{st: ST_RUNNING, wake: w_sm_rdata.wake};
                            if ((r_cmd != CMD_START) && (r_chk_idx == r_cur)) begin
                                // current task woke up itself
                                n_res_status = STAT_NO_SWITCH;
                                n_state      = S_OUT;
                            end else begin
                                w_sp_raddr = r_chk_idx;
                                n_state    = S_FIN;
                            end
                        end
                    end else if (r_chk_last) begin
                        n_chk_vld    = 1'b0;
                        n_res_status = (r_cmd == CMD_CREATE) ? STAT_NO_FREE : STAT_NONE_READY;
                        n_state      = S_OUT;
                    end
                end
            end

            S_FIN: begin
                n_res_status = STAT_OK;
                n_res_idx    = 3'(r_found);
                n_res_sp     = w_sp_rdata;
                n_res_sw     = 1'b1;
                n_cur        = r_found;
                n_started    = 1'b1;
                // a previous task that is still running goes back to ready
                if ((r_cmd != CMD_START) && (r_cur_st == ST_RUNNING)) begin
                    w_sm_we    = 1'b1;
                    w_sm_waddr = r_cur;
                    w_sm_wdata = '{st: ST_READY, wake: r_cur_wake};
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                // wait here until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_cur       <= '0;
            r_live      <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_started   <= n_started;
            r_cur       <= n_cur;
            r_live      <= n_live;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_isp        <= n_isp;
        r_ssp        <= n_ssp;
        r_ticks      <= n_ticks;
        r_now        <= n_now;
        r_cur_st     <= n_cur_st;
        r_cur_wake   <= n_cur_wake;
        r_issue_idx  <= n_issue_idx;
        r_issue_cnt  <= n_issue_cnt;
        r_chk_idx    <= n_chk_idx;
        r_chk_last   <= n_chk_last;
        r_found      <= n_found;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_sp     <= n_res_sp;
        r_res_sw     <= n_res_sw;
        if (w_out_load) begin
            r_o_status <= r_res_status;
            r_o_idx    <= r_res_idx;
            r_o_sp     <= r_res_sp;
            r_o_sw     <= r_res_sw;
            r_o_live   <= 4'(r_live);
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_o_status;
    assign o_res.task_index = r_o_idx;
    assign o_res.next_sp    = r_o_sp;
    assign o_res.switched   = r_o_sw;
    assign o_res.live_count = r_o_live;

endmodule
`default_nettype wire

### design/rrts_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rrts_checker
    import rrts_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic [1:0]  i_out_status,
    input wire logic [2:0]  i_out_task_index,
    input wire logic [31:0] i_out_next_sp,
    input wire logic        i_out_switched
);

    `RRTS_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !i_out_valid, "output valid after reset")
    `RRTS_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "accepted while busy")
    `RRTS_ASSERT(a_switch_ok, i_clk, i_rst_n, (i_out_valid && i_out_switched) |-> (i_out_status == STAT_OK), "switch with bad status")
    `RRTS_ASSERT(a_fail_clean, i_clk, i_rst_n, (i_out_valid && (i_out_status != STAT_OK)) |-> (!i_out_switched && (i_out_task_index == 3'd0) && (i_out_next_sp == 32'd0)), "stale fields on failure")

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_cmd.valid),
    .i_in_ready       (i_cmd.ready),
    .i_out_valid      (o_res.valid),
    .i_out_status     (o_res.status),
    .i_out_task_index (o_res.task_index),
    .i_out_next_sp    (o_res.next_sp),
    .i_out_switched   (o_res.switched)
);
`default_nettype wire
